FILE: sv/hwd_pkg.sv
// Shared types and constants for the Huffman tree-walk decoder.
`default_nettype none
package hwd_pkg;

  localparam int NODE_COUNT    = 512;
  localparam int NODE_AW       = $clog2(NODE_COUNT);
  localparam int IDX_W         = 9;
  localparam int SYM_W         = 8;
  localparam int CNT_W         = 31;
  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_CW        = $clog2(BITS_PER_BYTE + 1);
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;

  // input item kinds
  localparam logic KIND_NODE = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // register select, taken from paddr[2]
  localparam logic REG_ROOT  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic             leaf;
    logic [SYM_W-1:0] sym;
  } node_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CUR,
    ST_HIT,
    ST_FLUSH
  } state_t;

endpackage
`default_nettype wire

FILE: sv/hwd_in_if.sv
// Input channel: node table writes and compressed data bytes.
`default_nettype none
interface hwd_in_if
  import hwd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [IDX_W-1:0] node_index;
  logic [IDX_W-1:0] left_child;
  logic [IDX_W-1:0] right_child;
  logic             is_leaf;
  logic [SYM_W-1:0] leaf_symbol;
  logic [7:0]       data_byte;

  modport source (
    output valid, kind, node_index, left_child, right_child, is_leaf, leaf_symbol,
           data_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, node_index, left_child, right_child, is_leaf, leaf_symbol,
           data_byte,
    output ready
  );
endinterface
`default_nettype wire

FILE: sv/hwd_out_if.sv
// Result channel: decoded symbols.
`default_nettype none
interface hwd_out_if
  import hwd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;
  logic             finished;

  modport source (
    output valid, symbol, last, finished,
    input  ready
  );
  modport sink (
    input  valid, symbol, last, finished,
    output ready
  );
endinterface
`default_nettype wire

FILE: sv/huffman_tree_walk_decoder.sv
// Huffman decoder: a small sequencer walks a code tree held in a single-port node table.
// Node items are written straight into the table. A data byte is walked MSB first through the
// node table, which has one registered read port and sets the pace: the current node is
// fetched first, then one node is fetched per bit, the root is fetched again after each
// symbol that does not end the byte, and the byte's final symbol is handed to the output
// register. A data byte is taken and dropped while the count is at zero; otherwise the
// input is held off until the byte is walked and its final symbol handed on, longer if
// the sink stalls. The block takes no new item while a byte is being walked. Each symbol
// is held back one step so that the byte's final symbol can be marked last; a symbol that
// brings the count to zero ends the byte. root_index sits at byte address 0, symbol_count
// at 4; writing either returns the walk to the root.
`default_nettype none
module huffman_tree_walk_decoder
  import hwd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  hwd_in_if.sink                 in_ch,
  hwd_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  // node table
  node_t mem [NODE_COUNT];

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   root_r, root_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [CNT_W-1:0]   left_r, left_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic [BIT_CW-1:0]  bits_r, bits_nxt;
  logic [IDX_W-1:0]   next_r, next_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic [SYM_W-1:0]   pend_sym_r, pend_sym_nxt;
  logic               pend_fin_r, pend_fin_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]   out_sym_r, out_sym_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_fin_r, out_fin_nxt;
  node_t              rdata_r;
  logic               rd_ok_r;

  logic               in_fire;
  logic               cfg_wr;
  logic               slot_free;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_idx;
  logic               mem_we;
  node_t              wr_node;
  node_t              node;
  logic               emit_req;
  logic [SYM_W-1:0]   emit_sym;
  logic [IDX_W-1:0]   child;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign node      = rd_ok_r ? rdata_r : '0;  // out-of-range index reads as zero

  assign wr_node.left  = in_ch.left_child;
  assign wr_node.right = in_ch.right_child;
  assign wr_node.leaf  = in_ch.is_leaf;
  assign wr_node.sym   = in_ch.leaf_symbol;

  always_comb begin
    state_nxt      = state_r;
    root_nxt       = root_r;
    cur_nxt        = cur_r;
    left_nxt       = left_r;
    byte_nxt       = byte_r;
    bits_nxt       = bits_r;
    next_nxt       = next_r;
    pend_valid_nxt = pend_valid_r;
    pend_sym_nxt   = pend_sym_r;
    pend_fin_nxt   = pend_fin_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_sym_nxt    = out_sym_r;
    out_last_nxt   = out_last_r;
    out_fin_nxt    = out_fin_r;
    rd_en          = 1'b0;
    rd_idx         = cur_r;
    mem_we         = 1'b0;
    emit_req       = 1'b0;
    emit_sym       = node.sym;
    child          = byte_r[7] ? node.left : node.right;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.kind == KIND_NODE) begin
            mem_we = 32'(in_ch.node_index) < NODE_COUNT;
          end else if (left_r != '0) begin
            byte_nxt  = in_ch.data_byte;
            bits_nxt  = BIT_CW'(BITS_PER_BYTE);
            rd_en     = 1'b1;
            rd_idx    = cur_r;
            state_nxt = ST_CUR;
          end
        end
      end
      ST_CUR: begin
        if (node.leaf) begin
          emit_req = 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_idx    = child;
          next_nxt  = child;
          state_nxt = ST_HIT;
        end
      end
      ST_HIT: begin
        if (node.leaf) begin
          emit_req = 1'b1;
        end else begin
          // step down; the fetched child is the new current node
          cur_nxt  = next_r;
          byte_nxt = {byte_r[6:0], 1'b0};
          bits_nxt = bits_r - 1'b1;
          if (bits_r == BIT_CW'(1)) begin
            state_nxt = ST_FLUSH;
          end else begin
            child    = byte_r[6] ? node.left : node.right;
            rd_en    = 1'b1;
            rd_idx   = child;
            next_nxt = child;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_sym_nxt    = pend_sym_r;
          out_last_nxt   = 1'b1;
          out_fin_nxt    = pend_fin_r;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // a new symbol pushes the held one out with last clear; stall if the slot is busy
    if (emit_req && (!pend_valid_r || slot_free)) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_sym_nxt   = pend_sym_r;
        out_last_nxt  = 1'b0;
        out_fin_nxt   = pend_fin_r;
      end
      pend_valid_nxt = 1'b1;
      pend_sym_nxt   = emit_sym;
      pend_fin_nxt   = left_r == CNT_W'(1);
      left_nxt       = left_r - 1'b1;
      cur_nxt        = root_r;
      byte_nxt       = {byte_r[6:0], 1'b0};
      bits_nxt       = bits_r - 1'b1;
      if (left_r == CNT_W'(1) || bits_r == BIT_CW'(1)) begin
        state_nxt = ST_FLUSH;
      end else begin
        rd_en     = 1'b1;
        rd_idx    = root_r;
        state_nxt = ST_CUR;
      end
    end

    if (cfg_wr) begin
      if (paddr[2] == REG_ROOT) begin
        root_nxt = pwdata[IDX_W-1:0];
        cur_nxt  = pwdata[IDX_W-1:0];
      end else begin
        left_nxt = pwdata[CNT_W-1:0];
        cur_nxt  = root_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      root_r       <= '0;
      cur_r        <= '0;
      left_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      root_r       <= root_nxt;
      cur_r        <= cur_nxt;
      left_r       <= left_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    bits_r     <= bits_nxt;
    next_r     <= next_nxt;
    pend_sym_r <= pend_sym_nxt;
    pend_fin_r <= pend_fin_nxt;
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
    out_fin_r  <= out_fin_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[NODE_AW'(in_ch.node_index)] <= wr_node;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[NODE_AW'(rd_idx)];
      rd_ok_r <= 32'(rd_idx) < NODE_COUNT;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROOT:  prdata = CFG_DW'(root_r);
      REG_COUNT: prdata = CFG_DW'(left_r);
      default:   prdata = '0;
    endcase
  end

  assign pready         = 1'b1;
  assign in_ch.ready    = state_r == ST_IDLE;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.symbol  = out_sym_r;
  assign out_ch.last    = out_last_r;
  assign out_ch.finished = out_fin_r;

  // no symbol may be held back once the byte is done
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_valid_r)
    else $error("held symbol left behind at end of byte");

  // the symbol count only falls, except on a register write
  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_wr |=> (left_r <= $past(left_r)))
    else $error("symbol count rose without a write");

  // the symbol that exhausts the count always ends its byte
  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fin_r) |-> out_last_r)
    else $error("finished symbol not marked last");

endmodule
`default_nettype wire
